// File: sv/mbps_pkg.sv
// Shared constants and types for the masked byte pattern search block.
package mbps_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int PAT_STORE   = 32;
  localparam int LEN_LIMIT   = (PATTERN_MAX < PAT_STORE) ? PATTERN_MAX : PAT_STORE;
  localparam int CELL_IDX_W  = (LEN_LIMIT > 1) ? $clog2(LEN_LIMIT) : 1;

  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 6;
  localparam int WORD_W   = 64;
  localparam int CARE_W   = 32;
  localparam int SEEN_W   = 33;
  localparam int OFFSET_W = 32;
  localparam int APB_DW   = 64;
  localparam int APB_AW   = 6;
  localparam int REG_IDX_W = 3;

  localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};

  // register index codes (byte address = 8 * index)
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LEN = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_0   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_1   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_2   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_3   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CARE_MASK   = 3'd5;

  typedef struct packed {
    logic advance;  // byte transfer this cycle
    logic clear;    // byte closes the region
  } cell_ctl_t;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] match_offset;
  } result_t;

endpackage

// File: sv/mbps_if.sv
// Valid/ready channel interfaces for region bytes and search results.
interface mbps_in_if;
  logic                        valid;
  logic                        ready;
  logic [mbps_pkg::BYTE_W-1:0] data_byte;
  logic                        last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface mbps_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [mbps_pkg::OFFSET_W-1:0] match_offset;

  modport source (output valid, found, match_offset, input ready);
  modport sink (input valid, found, match_offset, output ready);
endinterface

// File: sv/masked_byte_pattern_search.sv
// A result is registered in the two-entry buffer from the byte transfer that causes it.
// Throughput: one region byte per cycle; the cell row checks every pattern prefix
// in parallel and the two-entry result buffer keeps input open while one waits.
// Input stalls only when both result entries are full.
// Reset (rst, synchronous, active high): registers zero, cells clear, buffer empty.
// Top level: masked byte pattern search with APB configuration.
module masked_byte_pattern_search (
  input  logic                           clk,
  input  logic                           rst,
  // APB configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mbps_pkg::APB_AW-1:0]    paddr,
  input  logic [mbps_pkg::APB_DW-1:0]    pwdata,
  output logic [mbps_pkg::APB_DW-1:0]    prdata,
  output logic                           pready,
  // streams
  mbps_in_if.sink                        in_ch,
  mbps_out_if.source                     out_ch
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [mbps_pkg::LEN_W-1:0]  pattern_len;
  logic [mbps_pkg::WORD_W-1:0] pattern_word [4];
  logic [mbps_pkg::CARE_W-1:0] care_mask;
  logic [mbps_pkg::REG_IDX_W-1:0] reg_idx;
  logic                        cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[mbps_pkg::APB_AW-1:mbps_pkg::APB_AW-mbps_pkg::REG_IDX_W];
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_len     <= '0;
      pattern_word[0] <= '0;
      pattern_word[1] <= '0;
      pattern_word[2] <= '0;
      pattern_word[3] <= '0;
      care_mask       <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        mbps_pkg::REG_PATTERN_LEN: pattern_len     <= pwdata[mbps_pkg::LEN_W-1:0];
        mbps_pkg::REG_PATTERN_0:   pattern_word[0] <= pwdata;
        mbps_pkg::REG_PATTERN_1:   pattern_word[1] <= pwdata;
        mbps_pkg::REG_PATTERN_2:   pattern_word[2] <= pwdata;
        mbps_pkg::REG_PATTERN_3:   pattern_word[3] <= pwdata;
        mbps_pkg::REG_CARE_MASK:   care_mask       <= pwdata[mbps_pkg::CARE_W-1:0];
        default: ;  // unmapped addresses ignore writes
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mbps_pkg::REG_PATTERN_LEN: prdata = mbps_pkg::APB_DW'(pattern_len);
      mbps_pkg::REG_PATTERN_0:   prdata = pattern_word[0];
      mbps_pkg::REG_PATTERN_1:   prdata = pattern_word[1];
      mbps_pkg::REG_PATTERN_2:   prdata = pattern_word[2];
      mbps_pkg::REG_PATTERN_3:   prdata = pattern_word[3];
      mbps_pkg::REG_CARE_MASK:   prdata = mbps_pkg::APB_DW'(care_mask);
      default:                   prdata = '0;
    endcase
  end

  // Pattern bytes as one flat vector, byte 0 in the low bits.
  logic [4*mbps_pkg::WORD_W-1:0] pattern_flat;
  assign pattern_flat = {pattern_word[3], pattern_word[2], pattern_word[1], pattern_word[0]};

  // ---------------------------------------------------------------------
  // Input transfer and cell row
  // ---------------------------------------------------------------------
  logic                accept;
  logic                buf_can_push;
  mbps_pkg::cell_ctl_t cell_ctl;

  assign in_ch.ready      = buf_can_push;
  assign accept           = in_ch.valid & in_ch.ready;
  assign cell_ctl.advance = accept;
  assign cell_ctl.clear   = in_ch.last_byte;

  // Cell j holds "pattern bytes 0..j matched the bytes ending one transfer ago".
  // With the new byte, hit[j] says bytes 0..j match ending at this byte, so a
  // full match of length L shows on hit[L-1]. Clearing at region end means a
  // hit can never reach back into a previous region.
  logic [mbps_pkg::LEN_LIMIT-1:0] hit;
  logic [mbps_pkg::LEN_LIMIT:0]   chain;

  assign chain[0] = 1'b1;

  for (genvar j = 0; j < mbps_pkg::LEN_LIMIT; j++) begin : g_cell
    logic chain_next;

    mbps_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (cell_ctl),
      .data_byte (in_ch.data_byte),
      .pat_byte  (pattern_flat[j*mbps_pkg::BYTE_W +: mbps_pkg::BYTE_W]),
      .care      (care_mask[j]),
      .chain_in  (chain[j]),
      .hit       (hit[j]),
      .chain_out (chain_next)
    );

    assign chain[j+1] = chain_next;
  end

  // ---------------------------------------------------------------------
  // Match select, byte count, offset
  // ---------------------------------------------------------------------
  logic [mbps_pkg::LEN_W-1:0]      eff_len;
  logic [mbps_pkg::LEN_W-1:0]      len_minus1;
  logic [mbps_pkg::CELL_IDX_W-1:0] sel_idx;
  logic                            hit_sel;

  // lengths above the cell count clamp to the full row
  assign eff_len    = (pattern_len > mbps_pkg::LEN_W'(mbps_pkg::LEN_LIMIT)) ?
                      mbps_pkg::LEN_W'(mbps_pkg::LEN_LIMIT) : pattern_len;
  assign len_minus1 = eff_len - mbps_pkg::LEN_W'(1);
  assign sel_idx    = len_minus1[mbps_pkg::CELL_IDX_W-1:0];
  assign hit_sel    = (eff_len != '0) & hit[sel_idx];

  logic [mbps_pkg::SEEN_W-1:0] bytes_seen;
  logic [mbps_pkg::SEEN_W-1:0] seen_inc;
  logic [mbps_pkg::SEEN_W-1:0] start_off;
  logic                        match_latched;

  // saturating count including the byte in flight
  assign seen_inc  = (bytes_seen == mbps_pkg::SEEN_MAX) ? bytes_seen :
                     bytes_seen + mbps_pkg::SEEN_W'(1);
  // no underflow: a hit needs eff_len bytes of this region
  assign start_off = seen_inc - mbps_pkg::SEEN_W'(eff_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen    <= '0;
      match_latched <= 1'b0;
    end else if (accept) begin
      if (in_ch.last_byte) begin
        bytes_seen    <= '0;
        match_latched <= 1'b0;
      end else begin
        bytes_seen    <= seen_inc;
        match_latched <= match_latched | hit_sel;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result generation: first match of a region, or not-found at its end
  // ---------------------------------------------------------------------
  logic              push;
  mbps_pkg::result_t result;

  assign push         = accept & ~match_latched & (hit_sel | in_ch.last_byte);
  assign result.found = hit_sel;

  always_comb begin
    if (!hit_sel) begin
      result.match_offset = '0;
    end else if (start_off[mbps_pkg::SEEN_W-1]) begin
      result.match_offset = '1;  // saturate past 32 bits
    end else begin
      result.match_offset = start_off[mbps_pkg::OFFSET_W-1:0];
    end
  end

  mbps_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .can_push  (buf_can_push),
    .out_ch    (out_ch)
  );

endmodule

// File: sv/mbps_cell.sv
// One compare cell: partial-match bit for pattern prefix ending at its byte.
module mbps_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  mbps_pkg::cell_ctl_t         ctl,
  input  logic [mbps_pkg::BYTE_W-1:0] data_byte,
  input  logic [mbps_pkg::BYTE_W-1:0] pat_byte,
  input  logic                        care,
  input  logic                        chain_in,
  output logic                        hit,
  output logic                        chain_out
);

  logic prefix;

  // prefix through this byte matches when the shorter prefix matched last byte
  assign hit       = chain_in & (~care | (data_byte == pat_byte));
  assign chain_out = prefix;

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix <= 1'b0;
    end else if (ctl.advance) begin
      prefix <= ctl.clear ? 1'b0 : hit;
    end
  end

endmodule

// File: sv/mbps_out_buf.sv
// Two-entry result buffer: output register plus skid entry.
module mbps_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mbps_pkg::result_t   push_data,
  output logic                can_push,
  mbps_out_if.source          out_ch
);

  logic              main_valid;
  logic              skid_valid;
  mbps_pkg::result_t main_data;
  mbps_pkg::result_t skid_data;
  logic              pop;

  assign pop      = main_valid & out_ch.ready;
  assign can_push = ~skid_valid;

  assign out_ch.valid        = main_valid;
  assign out_ch.found        = main_data.found;
  assign out_ch.match_offset = main_data.match_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_data <= skid_data;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

// File: sv/mbps_checker.sv
// Port-level checker for the masked byte pattern search, bound to the top level.
module mbps_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          pready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_found,
  input logic [mbps_pkg::OFFSET_W-1:0] out_match_offset
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_pready_high: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_found) |-> (out_match_offset == '0))
    else $error("not-found result with nonzero offset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_found) && $stable(out_match_offset)))
    else $error("stalled result changed");

endmodule

bind masked_byte_pattern_search mbps_checker u_mbps_checker (
  .clk              (clk),
  .rst              (rst),
  .pready           (pready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_found        (out_ch.found),
  .out_match_offset (out_ch.match_offset)
);
